/* hw/rtl/mahd_pkg.sv */
// Shared constants, types and register codes of the multichannel average detector.
package mahd_pkg;

  // Default values of the top-level parameters.
  localparam int N_CHANNELS_DEF  = 4;
  localparam int AVG_DEPTH_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 10;

  // Value that every window entry holds after reset, and the bits it needs.
  localparam int INIT_SAMPLE = 512;
  localparam int INIT_W      = 10;

  // Configuration register file.
  localparam int THR_REGS   = 4;
  localparam int THR_IDX_W  = 2;
  localparam int THR_W      = 10;
  localparam int MARGIN_W   = 9;
  localparam int MIN_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd5;

  localparam logic [THR_W-1:0]    THR_RESET    = 10'd512;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 9'd16;
  localparam logic [MIN_W-1:0]    MIN_RESET    = 10'd0;

  // Width of the reported channel number.
  localparam int CHAN_OUT_W = 2;

  // Entries of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_DETECT  = 2'd1,
    EV_RELEASE = 2'd2
  } event_t;

  typedef struct packed {
    logic [THR_REGS-1:0][THR_W-1:0] thr;
    logic [MARGIN_W-1:0]            margin;
    logic [MIN_W-1:0]               minimum_level;
  } cfg_t;

endpackage

/* hw/rtl/mahd_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module mahd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/mahd_front.sv */
// Front part: takes samples, walks the channels and slots, and updates the window sums.
module mahd_front
  import mahd_pkg::*;
#(
  parameter int N_CHANNELS  = N_CHANNELS_DEF,
  parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CH_W  = (N_CHANNELS > 1) ? $clog2(N_CHANNELS) : 1,
  localparam int SLOT_W = $clog2(AVG_DEPTH),
  localparam int OLD_W = (SAMPLE_BITS > INIT_W) ? SAMPLE_BITS : INIT_W,
  localparam int SUM_W = OLD_W + SLOT_W,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [CNT_W-1:0]       q_count,
  output logic                   push,
  output logic [CH_W-1:0]        push_ch,
  output logic [SUM_W-1:0]       push_sum
);

  localparam int ADDR_W = CH_W + SLOT_W;

  logic              accept;
  logic [CNT_W:0]    pending;
  logic [CH_W-1:0]   ch;
  logic [SLOT_W-1:0] slot;
  logic              lap_done;
  logic              last_ch;
  logic              last_slot;

  logic                   b_valid;
  logic [CH_W-1:0]        b_ch;
  logic [SLOT_W-1:0]      b_slot;
  logic [SAMPLE_BITS-1:0] b_sample;
  logic                   b_fresh;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [OLD_W-1:0]       old_sample;
  logic [SUM_W-1:0]       new_sum;
  logic [SUM_W-1:0]       sums [N_CHANNELS];

  // Credits: the queue plus the update stage never hold more than the queue takes.
  assign pending      = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(b_valid);
  assign sample_stall = pending >= (CNT_W + 1)'(QUEUE_DEPTH);
  assign accept       = sample_valid && !sample_stall;

  assign last_ch   = ch == CH_W'(N_CHANNELS - 1);
  assign last_slot = slot == SLOT_W'(AVG_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ch       <= '0;
      slot     <= '0;
      lap_done <= 1'b0;
    end else if (accept) begin
      if (last_ch) begin
        ch <= '0;
        if (last_slot) begin
          slot     <= '0;
          lap_done <= 1'b1;
        end else begin
          slot <= slot + 1'b1;
        end
      end else begin
        ch <= ch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_ch     <= ch;
      b_slot   <= slot;
      b_sample <= sample;
      b_fresh  <= !lap_done;
    end
  end

  mahd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (2 ** ADDR_W)
  ) u_window_ram (
    .clk   (clk),
    .we    (b_valid),
    .waddr ({b_ch, b_slot}),
    .wdata (b_sample),
    .re    (accept),
    .raddr ({ch, slot}),
    .rdata (rdata)
  );

  // During the first lap every slot is read before it is ever written.
  assign old_sample = b_fresh ? OLD_W'(INIT_SAMPLE) : OLD_W'(rdata);
  assign new_sum    = sums[b_ch] - SUM_W'(old_sample) + SUM_W'(b_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_CHANNELS; i++) begin
        sums[i] <= SUM_W'(INIT_SAMPLE * AVG_DEPTH);
      end
    end else if (b_valid) begin
      sums[b_ch] <= new_sum;
    end
  end

  assign push     = b_valid;
  assign push_ch  = b_ch;
  assign push_sum = new_sum;

endmodule

/* hw/rtl/mahd_fifo.sv */
// Short first-in first-out queue between the front and the back.
module mahd_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             rvalid,
  output logic [WIDTH-1:0] rdata,
  output logic [CNT_W-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign rvalid = count != '0;
  assign rdata  = mem[rd_ptr];

endmodule

/* hw/rtl/mahd_back.sv */
// Back part: divides the window sum and applies the per-channel hysteresis.
module mahd_back
  import mahd_pkg::*;
#(
  parameter int N_CHANNELS  = N_CHANNELS_DEF,
  parameter int AVG_DEPTH   = AVG_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CH_W  = (N_CHANNELS > 1) ? $clog2(N_CHANNELS) : 1,
  localparam int SLOT_W = $clog2(AVG_DEPTH),
  localparam int OLD_W = (SAMPLE_BITS > INIT_W) ? SAMPLE_BITS : INIT_W,
  localparam int SUM_W = OLD_W + SLOT_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  input  logic [CH_W+SUM_W-1:0]    q_data,
  output logic                     pop,
  input  mahd_pkg::cfg_t           cfg,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [CHAN_OUT_W-1:0]    channel_index,
  output logic [SAMPLE_BITS-1:0]   average,
  output logic                     clear_flag,
  output logic [1:0]               event_res
);

  // Exact division by the window depth through a reciprocal.
  localparam int SHIFT   = SUM_W + SLOT_W;
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint RECIP = ((64'd1 << SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam int CMP_W = ((SAMPLE_BITS > THR_W + 1) ? SAMPLE_BITS : THR_W + 1) + 1;

  logic [CH_W-1:0]        q_ch;
  logic [SUM_W-1:0]       q_sum;
  logic [PROD_W-1:0]      product;
  logic [SAMPLE_BITS-1:0] q_avg;

  logic                   o_free;
  logic                   p_free;
  logic                   p_valid;
  logic [CH_W-1:0]        p_ch;
  logic [SAMPLE_BITS-1:0] p_avg;

  logic                    flags [N_CHANNELS];
  logic [THR_W-1:0]        thr;
  logic [CMP_W-1:0]        avg_c;
  logic [CMP_W-1:0]        hi_bound;
  logic signed [CMP_W-1:0] lo_bound;
  logic signed [CMP_W-1:0] avg_s;
  logic                    flag_new;
  event_t                  ev;

  assign q_ch    = q_data[SUM_W +: CH_W];
  assign q_sum   = q_data[SUM_W-1:0];
  assign product = PROD_W'(q_sum) * PROD_W'(RECIP_W'(RECIP));
  assign q_avg   = product[SHIFT +: SAMPLE_BITS];

  assign o_free = !result_valid || !result_stall;
  assign p_free = !p_valid || o_free;
  assign pop    = q_valid && p_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_free) begin
      p_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      p_ch  <= q_ch;
      p_avg <= q_avg;
    end
  end

  assign thr      = cfg.thr[THR_IDX_W'(p_ch)];
  assign avg_c    = CMP_W'(p_avg);
  assign avg_s    = signed'(avg_c);
  assign hi_bound = CMP_W'(thr) + CMP_W'(cfg.margin);
  assign lo_bound = signed'(CMP_W'(thr)) - signed'(CMP_W'(cfg.margin));

  always_comb begin
    flag_new = flags[p_ch];
    ev       = EV_NONE;
    if (!flags[p_ch]) begin
      if (avg_c > hi_bound) begin
        flag_new = 1'b1;
        ev       = EV_RELEASE;
      end
    end else begin
      if ((avg_s < lo_bound) && (avg_c > CMP_W'(cfg.minimum_level))) begin
        flag_new = 1'b0;
        ev       = EV_DETECT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      for (int i = 0; i < N_CHANNELS; i++) begin
        flags[i] <= 1'b0;
      end
    end else if (o_free) begin
      result_valid <= p_valid;
      if (p_valid) begin
        flags[p_ch] <= flag_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && p_valid) begin
      channel_index <= CHAN_OUT_W'(p_ch);
      average       <= p_avg;
      clear_flag    <= flag_new;
      event_res     <= ev;
    end
  end

endmodule

/* hw/rtl/mahd_cfg.sv */
// Configuration register file: channel thresholds, margin and minimum level.
module mahd_cfg
  import mahd_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mahd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mahd_pkg::CFG_DATA_W-1:0] cfg_data,
  output mahd_pkg::cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THR_REGS; i++) begin
        cfg.thr[i] <= THR_RESET;
      end
      cfg.margin        <= MARGIN_RESET;
      cfg.minimum_level <= MIN_RESET;
    end else if (cfg_valid) begin
      priority if (cfg_index < CFG_IDX_W'(THR_REGS)) begin
        cfg.thr[cfg_index[THR_IDX_W-1:0]] <= cfg_data[THR_W-1:0];
      end else if (cfg_index == REG_MARGIN) begin
        cfg.margin <= cfg_data[MARGIN_W-1:0];
      end else if (cfg_index == REG_MIN) begin
        cfg.minimum_level <= cfg_data[MIN_W-1:0];
      end else begin
        // Writes to unused indexes are dropped.
      end
    end
  end

endmodule

/* hw/rtl/multichannel_avg_hysteresis_detector_unit.sv */
// Top level of the multichannel moving-average detector with hysteresis.
//
//   Channel   Direction  Handshake              Payload
//   sample    in         sample_valid/stall     sample
//   result    out        result_valid/stall     channel_index, average, clear_flag, event_res
//   config    in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One sample transaction is taken in every clock cycle while sample_stall is low; its
// result passes the update stage, the queue, the divide stage and the output register.
// The sustained rate is set by the single read and single write port of the window RAM.
// Reset needs no clearing pass: until the first full lap over all channels and slots has
// passed, a window entry reads as 512, so the block takes samples at once after reset.
// A stalled result backs up through the four-entry queue; sample_stall rises when the queue
// and the update stage together hold four transactions.
module multichannel_avg_hysteresis_detector_unit
  import mahd_pkg::*;
#(
  parameter int N_CHANNELS  = mahd_pkg::N_CHANNELS_DEF,
  parameter int AVG_DEPTH   = mahd_pkg::AVG_DEPTH_DEF,
  parameter int SAMPLE_BITS = mahd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [SAMPLE_BITS-1:0]          sample,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [mahd_pkg::CHAN_OUT_W-1:0] channel_index,
  output logic [SAMPLE_BITS-1:0]          average,
  output logic                            clear_flag,
  output logic [1:0]                      event_res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mahd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mahd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CH_W   = (N_CHANNELS > 1) ? $clog2(N_CHANNELS) : 1;
  localparam int SLOT_W = $clog2(AVG_DEPTH);
  localparam int OLD_W  = (SAMPLE_BITS > INIT_W) ? SAMPLE_BITS : INIT_W;
  localparam int SUM_W  = OLD_W + SLOT_W;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  cfg_t                 cfg;
  logic                 front_push;
  logic [CH_W-1:0]      front_ch;
  logic [SUM_W-1:0]     front_sum;
  logic                 q_valid;
  logic [CH_W+SUM_W-1:0] q_data;
  logic                 q_pop;
  logic [CNT_W-1:0]     q_count;

  // Register file; it is to be written only while no transaction is in flight, which the block does not enforce.
  mahd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The front owns the round-robin position, the window RAM and the running sums.
  mahd_front #(
    .N_CHANNELS  (N_CHANNELS),
    .AVG_DEPTH   (AVG_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .q_count      (q_count),
    .push         (front_push),
    .push_ch      (front_ch),
    .push_sum     (front_sum)
  );

  // The queue carries the channel number and the updated sum of each transaction.
  mahd_fifo #(
    .WIDTH (CH_W + SUM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (front_push),
    .wdata  ({front_ch, front_sum}),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_data),
    .count  (q_count)
  );

  // The back divides by the window depth, then applies the hysteresis per channel.
  mahd_back #(
    .N_CHANNELS  (N_CHANNELS),
    .AVG_DEPTH   (AVG_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .pop           (q_pop),
    .cfg           (cfg),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .channel_index (channel_index),
    .average       (average),
    .clear_flag    (clear_flag),
    .event_res     (event_res)
  );

  // The credit check in the front must keep the queue from ever overflowing.
  a_queue_no_overflow : assert property (@(posedge clk) disable iff (rst)
    front_push |-> (q_count < CNT_W'(QUEUE_DEPTH)))
    else $error("queue push while full");

  // A detect event always leaves the channel flagged near.
  a_detect_near : assert property (@(posedge clk) disable iff (rst)
    (result_valid && (event_res == EV_DETECT)) |-> !clear_flag)
    else $error("detect event with clear flag set");

  // A release event always leaves the channel flagged clear.
  a_release_clear : assert property (@(posedge clk) disable iff (rst)
    (result_valid && (event_res == EV_RELEASE)) |-> clear_flag)
    else $error("release event with clear flag low");

endmodule

/* test/multichannel_avg_hysteresis_detector_unit_tb.sv */
// Self-checking testbench of the multichannel moving-average detector with hysteresis.
module multichannel_avg_hysteresis_detector_unit_tb;
  import mahd_pkg::*;

  // The block is built with its default sizes, and the predictor mirrors them.
  localparam int N_CH           = N_CHANNELS_DEF;
  localparam int DEPTH          = AVG_DEPTH_DEF;
  localparam int RESULT_LATENCY = 4;
  localparam int QUIET_LIMIT    = 1000;
  localparam int RX_HOLD_CYCLES = 120;
  localparam int RX_HOLD_AFTER  = 120;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 90;
  localparam int DIR_ROWS       = 26;

  // Register indexes that the package leaves unnamed. Indexes six and seven decode to
  // nothing, and writing them must leave every register untouched.
  localparam logic [CFG_IDX_W-1:0] REG_THR0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  typedef struct packed {
    logic [CHAN_OUT_W-1:0] chan;
    logic [9:0]            avg;
    logic                  clr;
    event_t                ev;
  } det_result_t;

  // One row of the directed table: either a register write or a sample. A sample row may
  // carry a result typed in by hand, which then replaces the predicted one.
  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [9:0]           data;
    bit                   typed;
    det_result_t          res;
  } dir_row_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  logic [9:0]            sample       = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [CHAN_OUT_W-1:0] channel_index;
  logic [9:0]            average;
  logic                  clear_flag;
  logic [1:0]            event_res;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Predictor state: the windows, their sums, the hysteresis flags and the visit order,
  // together with its own copy of the register file.
  logic [9:0]          win_mem   [N_CH][DEPTH];
  logic [13:0]         win_sum   [N_CH];
  logic                clr_state [N_CH];
  int                  cur_ch;
  int                  cur_slot;
  logic [THR_W-1:0]    thr_cfg   [THR_REGS];
  logic [MARGIN_W-1:0] margin_cfg;
  logic [MIN_W-1:0]    min_cfg;

  // Per-channel swing of the random samples between well above and well below the band.
  int swing_cnt [N_CH];
  bit swing_hi  [N_CH];

  det_result_t expected_q [$];
  dir_row_t    dir_tab [DIR_ROWS];
  int          err_cnt      = 0;
  int          results_seen = 0;

  multichannel_avg_hysteresis_detector_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .sample        (sample),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .channel_index (channel_index),
    .average       (average),
    .clear_flag    (clear_flag),
    .event_res     (event_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // Puts the predictor into the state that the block has after reset.
  task automatic reset_model();
    for (int c = 0; c < N_CH; c++) begin
      for (int k = 0; k < DEPTH; k++) begin
        win_mem[c][k] = 10'(INIT_SAMPLE);
      end
      win_sum[c]   = 14'(INIT_SAMPLE * DEPTH);
      clr_state[c] = 1'b0;
      swing_cnt[c] = 0;
      swing_hi[c]  = 1'b0;
    end
    for (int t = 0; t < THR_REGS; t++) begin
      thr_cfg[t] = THR_RESET;
    end
    margin_cfg = MARGIN_RESET;
    min_cfg    = MIN_RESET;
    cur_ch     = 0;
    cur_slot   = 0;
  endtask

  // Moves one sample through the window of the current channel and applies the
  // hysteresis. The lower bound is taken as a signed value, so a threshold smaller
  // than the margin gives a negative bound and no detect can follow.
  function automatic det_result_t predict_detection(input logic [9:0] s);
    det_result_t r;
    int avg;
    int thr;
    int marg;
    int floor_lvl;
    int low_bound;
    win_sum[cur_ch] = win_sum[cur_ch] - win_mem[cur_ch][cur_slot] + s;
    win_mem[cur_ch][cur_slot] = s;
    avg       = int'(win_sum[cur_ch]) / DEPTH;
    thr       = int'(thr_cfg[cur_ch % THR_REGS]);
    marg      = int'(margin_cfg);
    floor_lvl = int'(min_cfg);
    r.ev      = EV_NONE;
    if (!clr_state[cur_ch]) begin
      if (avg > thr + marg) begin
        clr_state[cur_ch] = 1'b1;
        r.ev = EV_RELEASE;
      end
    end else begin
      low_bound = thr - marg;
      if (avg < low_bound && avg > floor_lvl) begin
        clr_state[cur_ch] = 1'b0;
        r.ev = EV_DETECT;
      end
    end
    r.chan = cur_ch[CHAN_OUT_W-1:0];
    r.avg  = avg[9:0];
    r.clr  = clr_state[cur_ch];
    if (cur_ch == N_CH - 1) begin
      cur_ch   = 0;
      cur_slot = (cur_slot + 1) % DEPTH;
    end else begin
      cur_ch = cur_ch + 1;
    end
    return r;
  endfunction

  // Row builders for the directed table.
  function automatic dir_row_t sr(input logic [9:0] s);
    dir_row_t r;
    r        = '0;
    r.data   = s;
    r.res.ev = EV_NONE;
    return r;
  endfunction

  function automatic dir_row_t tr(input logic [9:0] s, input logic [CHAN_OUT_W-1:0] c,
                                  input logic [9:0] a, input logic f, input event_t e);
    dir_row_t r;
    r         = sr(s);
    r.typed   = 1'b1;
    r.res.chan = c;
    r.res.avg  = a;
    r.res.clr  = f;
    r.res.ev   = e;
    return r;
  endfunction

  function automatic dir_row_t cr(input logic [CFG_IDX_W-1:0] i, input logic [9:0] d);
    dir_row_t r;
    r        = sr(d);
    r.is_cfg = 1'b1;
    r.idx    = i;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a calm stretch.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Register values: the extremes often, otherwise anything in range.
  function automatic logic [9:0] pick_reg(input int hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return '0;
    if (r == 1) return hi[9:0];
    return 10'($urandom_range(0, hi));
  endfunction

  // Random samples for the channel that is due next. Most of them swing the channel's
  // average across the hysteresis band, so that detects and releases keep coming; the
  // rest are uniform values and extremes.
  function automatic logic [9:0] pick_sample();
    int r;
    int thr;
    int marg;
    int offs;
    int jit;
    int lvl;
    r = $urandom_range(0, 99);
    if (r < 8) return ($urandom_range(0, 1) != 0) ? 10'h3FF : 10'h000;
    if (r < 28) return 10'($urandom_range(0, 1023));
    swing_cnt[cur_ch] = swing_cnt[cur_ch] + 1;
    if (swing_cnt[cur_ch] >= 20) begin
      swing_cnt[cur_ch] = 0;
      swing_hi[cur_ch]  = !swing_hi[cur_ch];
    end
    thr  = int'(thr_cfg[cur_ch % THR_REGS]);
    marg = int'(margin_cfg);
    offs = $urandom_range(1, 80);
    jit  = $urandom_range(0, 40);
    lvl  = swing_hi[cur_ch] ? thr + marg + offs : thr - marg - offs;
    lvl  = lvl + jit - 20;
    if (lvl < 0) lvl = 0;
    if (lvl > 1023) lvl = 1023;
    return lvl[9:0];
  endfunction

  // Offers one sample and holds it until the block takes it, then records what the
  // block must report for it.
  task automatic send_sample(input logic [9:0] s, input bit typed, input det_result_t res);
    det_result_t want;
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall !== 1'b0);
    want = predict_detection(s);
    if (typed) want = res;
    expected_q.push_back(want);
  endtask

  task automatic sample_gap(input bit calm);
    int g;
    g = pick_gap(calm);
    if (g > 0) begin
      sample_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stops offering samples and waits until every outstanding result has come back, so
  // that the block is idle.
  task automatic drain();
    sample_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Writes one register. cfg_valid is left high, so that back-to-back writes need no
  // second assignment within a time step; the caller lowers it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [9:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx < THR_REGS) begin
      thr_cfg[idx[THR_IDX_W-1:0]] = data;
    end else if (idx == REG_MARGIN) begin
      margin_cfg = data[MARGIN_W-1:0];
    end else if (idx == REG_MIN) begin
      min_cfg = data;
    end
  endtask

  // A fresh setting between random phases. The margin is written with a random top bit,
  // which the block must drop; the minimum level is kept low most of the time, or
  // detects would hardly ever be allowed.
  task automatic random_config();
    logic [9:0] marg;
    logic [9:0] floor_lvl;
    write_reg(REG_THR0, pick_reg(1023));
    write_reg(REG_THR1, pick_reg(1023));
    write_reg(REG_THR2, pick_reg(1023));
    write_reg(REG_THR3, pick_reg(1023));
    marg = pick_reg(511);
    marg[9] = 1'($urandom_range(0, 1));
    write_reg(REG_MARGIN, marg);
    floor_lvl = ($urandom_range(0, 3) == 0) ? pick_reg(1023) : 10'($urandom_range(0, 300));
    write_reg(REG_MIN, floor_lvl);
    if ($urandom_range(0, 1) != 0) begin
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE6 : REG_SPARE7,
                10'($urandom_range(0, 1023)));
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Result checker. Each accepted result transaction is compared with the oldest
  // expectation; the values are read at the clock edge, before any update of that edge.
  always @(posedge clk) begin : result_check
    det_result_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual channel %0d average %0d",
                 $time, channel_index, average);
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("channel_index", 10'(want.chan), 10'(channel_index));
        check_field("average", want.avg, average);
        check_field("clear_flag", 10'(want.clr), 10'(clear_flag));
        check_field("event_res", 10'(want.ev), 10'(event_res));
      end
    end
  end

  // Receiver: random stalls of random length, calm stretches now and then, and once a
  // long hold-off while the sender keeps going, so that the queue fills and the block
  // stalls its sample input.
  initial begin : result_sink
    int  g;
    bit  hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      g = pick_gap(1'b0);
      if (!hold_done && results_seen >= RX_HOLD_AFTER) begin
        hold_done = 1'b1;
        g = RX_HOLD_CYCLES;
      end
      if (g > 0) begin
        result_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? 50 : $urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Watchdog: ends the run when no transaction of any kind has happened for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_valid === 1'b1 && sample_stall === 1'b0) ||
          (result_valid === 1'b1 && result_stall === 1'b0) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // Stimulus: the directed table first, then random phases, each with its own setting.
  initial begin : stimulus
    bit calm;
    reset_model();
    // After reset every window holds 512, so a sample of 1023 lifts the average to 543
    // and releases, a sample of 0 drops it to 480 and leaves the channel near. Later rows
    // bring channels one and three back below the band. Then the minimum level goes to its
    // top, which forbids any detect, and channel three gets a threshold below the margin.
    dir_tab = '{
      tr(10'd512,  2'd0, 10'd512, 1'b0, EV_NONE),
      tr(10'd1023, 2'd1, 10'd543, 1'b1, EV_RELEASE),
      tr(10'd0,    2'd2, 10'd480, 1'b0, EV_NONE),
      tr(10'd1023, 2'd3, 10'd543, 1'b1, EV_RELEASE),
      sr(10'd0), sr(10'd0), sr(10'd1023), sr(10'd0),
      sr(10'd0), sr(10'd0), sr(10'd1023), sr(10'd0),
      cr(REG_MIN, 10'd1023),
      cr(REG_MARGIN, 10'h3FF),
      cr(REG_THR3, 10'd0),
      cr(REG_THR0, 10'd1023),
      cr(REG_SPARE6, 10'h2AA),
      cr(REG_SPARE7, 10'h155),
      sr(10'd1023), sr(10'd0), sr(10'd1023), sr(10'd0),
      sr(10'd0), sr(10'd1023), sr(10'd0), sr(10'd1023)
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (dir_tab[k].is_cfg) begin
        drain();
        write_reg(dir_tab[k].idx, dir_tab[k].data);
        if (k + 1 == DIR_ROWS || !dir_tab[k + 1].is_cfg) cfg_valid <= 1'b0;
      end else begin
        send_sample(dir_tab[k].data, dir_tab[k].typed, dir_tab[k].res);
        sample_gap(1'b0);
      end
    end

    // Every phase starts from an idle block, which also makes the sender wait until each
    // outstanding result has come back.
    calm = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      random_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 30 == 0) calm = ($urandom_range(0, 3) == 0);
        send_sample(pick_sample(), 1'b0, '0);
        sample_gap(calm);
      end
    end

    drain();
    repeat (RESULT_LATENCY * 4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mahd_pkg.sv
hw/rtl/mahd_ram.sv
hw/rtl/mahd_front.sv
hw/rtl/mahd_fifo.sv
hw/rtl/mahd_back.sv
hw/rtl/mahd_cfg.sv
hw/rtl/multichannel_avg_hysteresis_detector_unit.sv
test/multichannel_avg_hysteresis_detector_unit_tb.sv
